// ===== rtl/anaglyph_pixel_merge_top_assert.svh =====
// Assertion macros for the anaglyph pixel merge block.
// Used by anaglyph_pixel_merge_top.sv; has no other dependencies.
`ifndef ANAGLYPH_PIXEL_MERGE_TOP_ASSERT_SVH
`define ANAGLYPH_PIXEL_MERGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/apm_pkg.sv =====
// Shared types and constants of the anaglyph pixel merge block.
// No dependencies.
`timescale 1ns / 1ps

package apm_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned PROD_W = 24;

    localparam logic [MODE_W-1:0] MODE_TRUE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COLOR     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OPTIMIZED = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_COLOR;

    // Unsigned Q0.16 weights; each set sums to 65536.
    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;
    localparam logic [15:0] OPT_WR  = 16'd6553;
    localparam logic [15:0] OPT_WG  = 16'd39322;
    localparam logic [15:0] OPT_WB  = 16'd19661;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Stage 1: weighted products, plus the channels that pass straight through.
    typedef struct packed {
        prod_t             ly_r;
        prod_t             ly_g;
        prod_t             ly_b;
        prod_t             ry_r;
        prod_t             ry_g;
        prod_t             ry_b;
        prod_t             lo_r;
        prod_t             lo_g;
        prod_t             lo_b;
        pix_t              left_red;
        pix_t              right_green;
        pix_t              right_blue;
        logic [MODE_W-1:0] mode;
    } prod_stage_t;

    // Stage 2: reduced channel values ready for the method select.
    typedef struct packed {
        pix_t              left_luma;
        pix_t              right_luma;
        pix_t              left_opt;
        pix_t              left_red;
        pix_t              right_green;
        pix_t              right_blue;
        logic [MODE_W-1:0] mode;
    } sum_stage_t;

endpackage

// ===== rtl/anaglyph_pixel_merge_top.sv =====
// Red-cyan anaglyph pixel merge: three-stage pipeline and mode register.
// Depends on apm_pkg and anaglyph_pixel_merge_top_assert.svh.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  pixel in  | start, busy (always low)  | left_red/green/blue, right_red/...
//  config    | cfg_valid, cfg_ready      | merge_mode
//  pixel out | done (one-cycle strobe)   | out_red, out_green, out_blue
//
// One pixel is taken every cycle; each result passes the stage 1, stage 2 and
// stage 3 registers before it appears on done. Stage 1 holds the nine 8x16 products,
// stage 2 the three reduced sums, stage 3 the selected output pixel.
// rst_n clears the stage valid bits and sets the mode register to color.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
`timescale 1ns / 1ps
`include "anaglyph_pixel_merge_top_assert.svh"

module anaglyph_pixel_merge_top
    import apm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        left_red,
    input  logic [7:0]        left_green,
    input  logic [7:0]        left_blue,
    input  logic [7:0]        right_red,
    input  logic [7:0]        right_green,
    input  logic [7:0]        right_blue,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        merge_mode,
    output logic              done,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue
);

    logic [MODE_W-1:0] mode_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    prod_stage_t       s1_reg;
    prod_stage_t       s1_next;
    sum_stage_t        s2_reg;
    sum_stage_t        s2_next;
    pix_t              red_reg;
    pix_t              red_next;
    pix_t              green_reg;
    pix_t              green_next;
    pix_t              blue_reg;
    pix_t              blue_next;
    logic              accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= merge_mode;
        end
    end

    // Stage 1: all products at once, each 8x16 into 24 bits.
    always_comb
    begin
        s1_next.ly_r        = PROD_W'(left_red)    * PROD_W'(LUMA_WR);
        s1_next.ly_g        = PROD_W'(left_green)  * PROD_W'(LUMA_WG);
        s1_next.ly_b        = PROD_W'(left_blue)   * PROD_W'(LUMA_WB);
        s1_next.ry_r        = PROD_W'(right_red)   * PROD_W'(LUMA_WR);
        s1_next.ry_g        = PROD_W'(right_green) * PROD_W'(LUMA_WG);
        s1_next.ry_b        = PROD_W'(right_blue)  * PROD_W'(LUMA_WB);
        s1_next.lo_r        = PROD_W'(left_red)    * PROD_W'(OPT_WR);
        s1_next.lo_g        = PROD_W'(left_green)  * PROD_W'(OPT_WG);
        s1_next.lo_b        = PROD_W'(left_blue)   * PROD_W'(OPT_WB);
        s1_next.left_red    = left_red;
        s1_next.right_green = right_green;
        s1_next.right_blue  = right_blue;
        s1_next.mode        = mode_reg;
    end

    // Stage 2: the weights sum to 65536, so each sum fits in 24 bits and
    // its top byte is the truncated result.
    always_comb
    begin
        prod_t ly_sum;
        prod_t ry_sum;
        prod_t lo_sum;
        ly_sum = s1_reg.ly_r + s1_reg.ly_g + s1_reg.ly_b;
        ry_sum = s1_reg.ry_r + s1_reg.ry_g + s1_reg.ry_b;
        lo_sum = s1_reg.lo_r + s1_reg.lo_g + s1_reg.lo_b;
        s2_next.left_luma   = ly_sum[PROD_W-1:PROD_W-PIX_W];
        s2_next.right_luma  = ry_sum[PROD_W-1:PROD_W-PIX_W];
        s2_next.left_opt    = lo_sum[PROD_W-1:PROD_W-PIX_W];
        s2_next.left_red    = s1_reg.left_red;
        s2_next.right_green = s1_reg.right_green;
        s2_next.right_blue  = s1_reg.right_blue;
        s2_next.mode        = s1_reg.mode;
    end

    // Stage 3: method select. Unused mode codes give a black pixel.
    always_comb
    begin
        case (s2_reg.mode)
            MODE_TRUE:
            begin
                red_next   = s2_reg.left_luma;
                green_next = '0;
                blue_next  = s2_reg.right_luma;
            end
            MODE_GRAY:
            begin
                red_next   = s2_reg.left_luma;
                green_next = s2_reg.right_luma;
                blue_next  = s2_reg.right_luma;
            end
            MODE_COLOR:
            begin
                red_next   = s2_reg.left_red;
                green_next = s2_reg.right_green;
                blue_next  = s2_reg.right_blue;
            end
            MODE_HALF:
            begin
                red_next   = s2_reg.left_luma;
                green_next = s2_reg.right_green;
                blue_next  = s2_reg.right_blue;
            end
            MODE_OPTIMIZED:
            begin
                red_next   = s2_reg.left_opt;
                green_next = s2_reg.right_green;
                blue_next  = s2_reg.right_blue;
            end
            default:
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done      = s3_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

    `APM_ASSERT_NOW(a_done_follows_start, clk, rst_n, done, $past(accept, 3), "done without a transfer three cycles before")
    `APM_ASSERT_NEXT(a_true_green_zero, clk, rst_n, s2_valid_reg && (s2_reg.mode == MODE_TRUE), done && (out_green == '0), "true mode must give zero green")
    `APM_ASSERT_NEXT(a_unused_black, clk, rst_n, s2_valid_reg && (s2_reg.mode > MODE_OPTIMIZED), done && (out_red == '0) && (out_green == '0) && (out_blue == '0), "unused mode must give black")
    `APM_ASSERT_NEXT(a_color_red_pass, clk, rst_n, s2_valid_reg && (s2_reg.mode == MODE_COLOR), out_red == $past(s2_reg.left_red), "color mode must pass left red")

endmodule

// ===== dv/tb_anaglyph_pixel_merge_top.sv =====
// Self-checking testbench for anaglyph_pixel_merge_top: a directed table, then random pixels.
// Each mode is checked against a predictor kept in this file.
// Depends on apm_pkg and the RTL of anaglyph_pixel_merge_top.
`timescale 1ns / 1ps

module tb_anaglyph_pixel_merge_top;
    import apm_pkg::*;

    localparam int unsigned CLK_HALF       = 10;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned RANDOM_PIXELS  = 450;
    localparam int unsigned PHASE_PIXELS   = 50;
    localparam int unsigned CALM_FROM      = 390;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned DIRECTED_ROWS  = 22;
    localparam int unsigned PLANNED_PHASES = 8;

    // Mode codes with no method behind them.
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        rgb_t              left;
        rgb_t              right;
        logic              fixed;
        rgb_t              want;
    } directed_row_t;

    // Rows with fixed set carry a result that can be read off directly.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_COLOR, {8'h00, 8'h00, 8'h00}, {8'h00, 8'h00, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00}},
        '{MODE_COLOR, {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 1'b1, {8'hFF, 8'hFF, 8'hFF}},
        '{MODE_COLOR, {8'hA5, 8'h5A, 8'h3C}, {8'h5A, 8'hA5, 8'hC3}, 1'b1, {8'hA5, 8'hA5, 8'hC3}},
        '{MODE_TRUE,  {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 1'b1, {8'hFF, 8'h00, 8'hFF}},
        '{MODE_TRUE,  {8'h00, 8'h00, 8'h00}, {8'h00, 8'h00, 8'h00}, 1'b1, {8'h00, 8'h00, 8'h00}},
        '{MODE_TRUE,  {8'hFF, 8'h00, 8'h00}, {8'h00, 8'h00, 8'hFF}, 1'b0, {8'h00, 8'h00, 8'h00}},
        '{MODE_TRUE,  {8'h00, 8'hFF, 8'h00}, {8'h00, 8'hFF, 8'h00}, 1'b0, {8'h00, 8'h00, 8'h00}},
        '{MODE_GRAY,  {8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h00}, 1'b1, {8'hFF, 8'h00, 8'h00}},
        '{MODE_GRAY,  {8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF}, 1'b1, {8'h00, 8'hFF, 8'hFF}},
        '{MODE_GRAY,  {8'h00, 8'h00, 8'hFF}, {8'hFF, 8'h00, 8'h00}, 1'b0, {8'h00, 8'h00, 8'h00}},
        '{MODE_HALF,  {8'hFF, 8'hFF, 8'hFF}, {8'h0C, 8'h22, 8'h38}, 1'b1, {8'hFF, 8'h22, 8'h38}},
        '{MODE_HALF,  {8'hFF, 8'h00, 8'h00}, {8'h00, 8'hFF, 8'h00}, 1'b0, {8'h00, 8'h00, 8'h00}},
        '{MODE_HALF,  {8'h55, 8'hAA, 8'h55}, {8'hAA, 8'h55, 8'hAA}, 1'b0, {8'h00, 8'h00, 8'h00}},
        '{MODE_OPTIMIZED, {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 1'b1,
          {8'hFF, 8'hFF, 8'hFF}},
        '{MODE_OPTIMIZED, {8'h00, 8'hFF, 8'h00}, {8'h00, 8'h01, 8'h02}, 1'b0,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_OPTIMIZED, {8'hFF, 8'h00, 8'hFF}, {8'h80, 8'h7F, 8'hFE}, 1'b0,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_OPTIMIZED, {8'h01, 8'h01, 8'h01}, {8'hFE, 8'hFE, 8'hFE}, 1'b0,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_UNUSED_LO,  {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 1'b1,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_UNUSED_MID, {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 1'b1,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_UNUSED_HI,  {8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 1'b1,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_UNUSED_HI,  {8'hA5, 8'h5A, 8'h3C}, {8'h5A, 8'hA5, 8'hC3}, 1'b1,
          {8'h00, 8'h00, 8'h00}},
        '{MODE_COLOR, {8'h01, 8'h80, 8'h7F}, {8'hFE, 8'h7F, 8'h80}, 1'b1, {8'h01, 8'h7F, 8'h80}}
    };

    localparam logic [MODE_W-1:0] PHASE_MODES [PLANNED_PHASES] = '{
        MODE_TRUE, MODE_UNUSED_HI, MODE_GRAY, MODE_OPTIMIZED,
        MODE_HALF, MODE_UNUSED_LO, MODE_COLOR, MODE_UNUSED_MID
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [7:0]        left_red;
    logic [7:0]        left_green;
    logic [7:0]        left_blue;
    logic [7:0]        right_red;
    logic [7:0]        right_green;
    logic [7:0]        right_blue;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MODE_W-1:0] merge_mode;
    logic              done;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;

    logic [MODE_W-1:0] mode_now;
    rgb_t              pending_pixels [$];
    int unsigned       pixels_sent;
    int unsigned       pixels_seen;
    int unsigned       mode_writes;
    int unsigned       mismatches;
    int unsigned       cycles;

    anaglyph_pixel_merge_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .left_red    (left_red),
        .left_green  (left_green),
        .left_blue   (left_blue),
        .right_red   (right_red),
        .right_green (right_green),
        .right_blue  (right_blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .merge_mode  (merge_mode),
        .done        (done),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Q0.16 weighted sum of one pixel, truncated to a byte.
    function automatic logic [7:0] weighted_byte(rgb_t px, logic [15:0] wr, logic [15:0] wg,
                                                  logic [15:0] wb);
        logic [31:0] acc;
        acc = 32'(px.red) * 32'(wr) + 32'(px.green) * 32'(wg) + 32'(px.blue) * 32'(wb);
        return acc[23:16];
    endfunction

    function automatic rgb_t merge_anaglyph(logic [MODE_W-1:0] mode, rgb_t left, rgb_t right);
        logic [7:0] left_luma;
        logic [7:0] right_luma;
        rgb_t       px;
        left_luma  = weighted_byte(left, LUMA_WR, LUMA_WG, LUMA_WB);
        right_luma = weighted_byte(right, LUMA_WR, LUMA_WG, LUMA_WB);
        px = '0;
        case (mode)
            MODE_TRUE:      px = {left_luma, 8'h00, right_luma};
            MODE_GRAY:      px = {left_luma, right_luma, right_luma};
            MODE_COLOR:     px = {left.red, right.green, right.blue};
            MODE_HALF:      px = {left_luma, right.green, right.blue};
            MODE_OPTIMIZED: px = {weighted_byte(left, OPT_WR, OPT_WG, OPT_WB),
                                  right.green, right.blue};
            default:        px = '0;
        endcase
        return px;
    endfunction

    // Extremes turn up often so that saturation corners are hit in every mode.
    function automatic rgb_t random_pixel();
        rgb_t        px;
        int unsigned pick;
        for (int i = 0; i < 3; i++)
        begin
            pick = $urandom_range(0, 7);
            px[8*i +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pixel(input rgb_t left, input rgb_t right, input logic fixed,
                              input rgb_t want);
        start       <= 1'b1;
        left_red    <= left.red;
        left_green  <= left.green;
        left_blue   <= left.blue;
        right_red   <= right.red;
        right_green <= right.green;
        right_blue  <= right.blue;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_pixels.push_back(fixed ? want : merge_anaglyph(mode_now, left, right));
        pixels_sent++;
        @(negedge clk);
    endtask

    // Lets every outstanding pixel come back, then lets the bench settle.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        drain_pipeline();
        repeat ($urandom_range(0, 3)) @(negedge clk);
        cfg_valid  <= 1'b1;
        merge_mode <= mode;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        mode_now = mode;
        mode_writes++;
        @(negedge clk);
        cfg_valid  <= 1'b0;
        merge_mode <= 3'($urandom_range(0, 7));
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycles, pending_pixels.size());
            $display("anaglyph_pixel_merge_top: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rgb_t want;
        rgb_t got;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            got = {out_red, out_green, out_blue};
            pixels_seen++;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel %h_%h_%h at cycle %0d",
                             got.red, got.green, got.blue, cycles);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (done !== 1'b1 || got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("pixel %0d: expected %h_%h_%h, got %h_%h_%h (done %b)",
                                 pixels_seen, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue, done);
                end
            end
        end
    end

    initial
    begin
        logic [MODE_W-1:0] phase_mode;
        rgb_t              left;
        rgb_t              right;
        rst_n       = 1'b0;
        start       = 1'b0;
        cfg_valid   = 1'b0;
        merge_mode  = MODE_COLOR;
        left_red    = '0;
        left_green  = '0;
        left_blue   = '0;
        right_red   = '0;
        right_green = '0;
        right_blue  = '0;
        mode_now    = MODE_RESET;
        pixels_sent = 0;
        pixels_seen = 0;
        mode_writes = 0;
        mismatches  = 0;
        cycles      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first rows run in the reset mode, with no write before them.
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (DIRECTED[row].mode != mode_now)
                write_mode(DIRECTED[row].mode);
            send_pixel(DIRECTED[row].left, DIRECTED[row].right, DIRECTED[row].fixed,
                       DIRECTED[row].want);
        end

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            if (n % PHASE_PIXELS == 0)
            begin
                if (n / PHASE_PIXELS < PLANNED_PHASES)
                    phase_mode = PHASE_MODES[n / PHASE_PIXELS];
                else
                    phase_mode = 3'($urandom_range(0, 7));
                write_mode(phase_mode);
            end
            // Hold off once mid-phase until the pipeline is empty.
            if (n == PHASE_PIXELS * 2 + PHASE_PIXELS / 2)
                drain_pipeline();
            if (n < CALM_FROM && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            left  = random_pixel();
            right = random_pixel();
            send_pixel(left, right, 1'b0, '0);
        end

        drain_pipeline();

        $display("sent %0d pixels over %0d mode writes covering all eight mode codes",
                 pixels_sent, mode_writes);
        $display("checked %0d merged pixels, %0d mismatches", pixels_seen, mismatches);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("anaglyph_pixel_merge_top: match");
        else
            $display("anaglyph_pixel_merge_top: mismatch");
        $finish;
    end

endmodule
